FILE: rtl/swcs_pkg.sv
`default_nettype none

package swcs_pkg;

  localparam int unsigned WINDOW_LEN_DEF  = 5;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned CHANNELS        = 7;
  localparam int unsigned CH_W            = 3;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  typedef struct packed {
    logic            cap;
    logic            acc_we;
    logic            acc_init;
    logic            latch;
    logic            sq;
    logic            spread;
    logic            root_start;
    logic            mean_start;
    logic            sd_start;
    logic            out_load;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic root_busy;
    logic mean_busy;
    logic sd_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/sliding_window_channel_statistics.sv
// Per-channel windowed statistics over seven signed sample channels.
// Input channel: one request carries a start_window flag and one sample per
// channel; it is taken when in_valid_i is high and in_stall_o is low.
// Each request is folded into per-channel running sum, sum of squares,
// maximum and minimum, one channel a cycle.
// When a window of WINDOW_LEN samples is complete, each channel is reduced
// in turn: mean and the scaling of the root by reciprocal multiplication,
// standard deviation through a bit-serial square root. The time taken per
// channel is set by the square root step count, and in_stall_o is high
// throughout a window-ending request.
// Output channel: one result request per channel, in channel order, from a
// single output register; out_valid_o holds with its payload while
// out_stall_i is high, and the reduction waits for the register to free.
// The next input request is taken while the final result still waits.
// Reset clears the window fill count and the output valid; the window then
// starts with the first request.

`default_nettype none

module sliding_window_channel_statistics #(
  parameter int unsigned WINDOW_LEN  = swcs_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = swcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          start_window_i,
  input  wire logic signed [SAMPLE_BITS-1:0] plate_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] plate_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0] plate_z_i,
  input  wire logic signed [SAMPLE_BITS-1:0] head_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] head_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0] head_z_i,
  input  wire logic signed [SAMPLE_BITS-1:0] supply_volts_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [swcs_pkg::CH_W-1:0]          channel_o,
  output logic signed [SAMPLE_BITS-1:0]      mean_value_o,
  output logic [SAMPLE_BITS-1:0]             std_value_o,
  output logic signed [SAMPLE_BITS-1:0]      max_value_o,
  output logic signed [SAMPLE_BITS-1:0]      min_value_o,
  output logic [SAMPLE_BITS-1:0]             span_value_o,
  output logic                               last_of_window_o
);

  swcs_pkg::cmd_t                                cmd;
  swcs_pkg::sts_t                                sts;
  logic [swcs_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] samples;

  assign samples = {supply_volts_i, head_z_i, head_y_i, head_x_i,
                    plate_z_i, plate_y_i, plate_x_i};

  swcs_ctrl #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_window_i(start_window_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  swcs_dp #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .samples_i       (samples),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .channel_o       (channel_o),
    .mean_value_o    (mean_value_o),
    .std_value_o     (std_value_o),
    .max_value_o     (max_value_o),
    .min_value_o     (min_value_o),
    .span_value_o    (span_value_o),
    .last_of_window_o(last_of_window_o)
  );

endmodule

`default_nettype wire

FILE: rtl/swcs_div.sv
`default_nettype none

module swcs_div #(
  parameter int unsigned DIVIDEND_W = 20,
  parameter int unsigned DIVISOR    = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  output logic                       busy_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned DVW = $clog2(DIVISOR);
  localparam int unsigned K   = DIVIDEND_W + DVW;
  localparam int unsigned MW  = DIVIDEND_W + 1;
  localparam int unsigned PW  = DIVIDEND_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic                  busy_q, busy_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [PW-1:0]         prod;

  assign prod = PW'(dvd_q) * PW'(RECIP);

  always_comb begin
    busy_d = 1'b0;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      quo_d = DIVIDEND_W'(prod >> K);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/swcs_sqrt.sv
`default_nettype none

module swcs_sqrt #(
  parameter int unsigned ROOT_W = 19
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [2*ROOT_W-1:0]   radicand_i,
  output logic                       busy_o,
  output logic [ROOT_W-1:0]          root_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [2*ROOT_W-1:0]   x_q, x_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_W+1:0]     rem_q, rem_d;
  logic [ROOT_W+3:0]     cand;
  logic [ROOT_W+3:0]     trial;
  logic [ROOT_W+3:0]     diff;
  logic                  ge;

  assign cand  = {rem_q, x_q[2*ROOT_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = cand >= trial;
  assign diff  = cand - trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = radicand_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[ROOT_W+1:0] : cand[ROOT_W+1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      x_d    = {x_q[2*ROOT_W-3:0], 2'b00};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/swcs_dp.sv
`default_nettype none

module swcs_dp #(
  parameter int unsigned WINDOW_LEN  = swcs_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = swcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire swcs_pkg::cmd_t                                cmd_i,
  output swcs_pkg::sts_t                                     sts_o,
  input  wire logic [swcs_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] samples_i,
  input  wire logic                                          out_stall_i,
  output logic                                               out_valid_o,
  output logic [swcs_pkg::CH_W-1:0]                          channel_o,
  output logic signed [SAMPLE_BITS-1:0]                      mean_value_o,
  output logic [SAMPLE_BITS-1:0]                             std_value_o,
  output logic signed [SAMPLE_BITS-1:0]                      max_value_o,
  output logic signed [SAMPLE_BITS-1:0]                      min_value_o,
  output logic [SAMPLE_BITS-1:0]                             span_value_o,
  output logic                                               last_of_window_o
);

  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned LW  = $clog2(WINDOW_LEN);
  localparam int unsigned RW  = S + LW;
  localparam int unsigned SQW = 2 * S + LW;
  localparam int unsigned SPW = 2 * RW;
  localparam int unsigned DW  = RW + 1;
  localparam int unsigned C   = swcs_pkg::CHANNELS;

  localparam logic [SPW-1:0] W_SP     = SPW'(WINDOW_LEN);
  localparam logic [DW-1:0]  W_DW     = DW'(WINDOW_LEN);

  logic [C-1:0][S-1:0]   sample_q;
  logic signed [RW-1:0]  sum_q   [C];
  logic [SQW-1:0]        sumsq_q [C];
  logic signed [S-1:0]   mx_q    [C];
  logic signed [S-1:0]   mn_q    [C];

  logic signed [S-1:0]   v;
  logic signed [2*S-1:0] vsq;
  logic signed [RW-1:0]  v_ext;
  logic [SQW-1:0]        vsq_ext;
  logic                  acc_wr;
  logic                  acc_init;

  logic signed [RW-1:0]  sum_r_q;
  logic [SQW-1:0]        sumsq_r_q;
  logic signed [S-1:0]   mx_r_q;
  logic signed [S-1:0]   mn_r_q;
  logic [SPW-1:0]        magsq_q;
  logic [SPW-1:0]        spread_q;
  logic                  neg;
  logic [RW-1:0]         mag;
  logic [DW-1:0]         mean_dividend;

  logic                  root_busy;
  logic [RW-1:0]         root;
  logic                  mean_busy;
  logic [DW-1:0]         mean_quo;
  logic                  sd_busy;
  logic [DW-1:0]         sd_quo;
  logic [S-1:0]          mean_mag;

  logic                  out_valid_q, out_valid_d;

  assign v        = sample_q[cmd_i.ch];
  assign vsq      = v * v;
  assign v_ext    = {{LW{v[S-1]}}, v};
  assign vsq_ext  = {{LW{1'b0}}, vsq};
  assign acc_wr   = cmd_i.acc_we || cmd_i.latch;
  assign acc_init = cmd_i.acc_init || cmd_i.latch;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      sample_q <= samples_i;
    end
    if (acc_wr) begin
      if (acc_init) begin
        sum_q[cmd_i.ch]   <= v_ext;
        sumsq_q[cmd_i.ch] <= vsq_ext;
        mx_q[cmd_i.ch]    <= v;
        mn_q[cmd_i.ch]    <= v;
      end else begin
        sum_q[cmd_i.ch]   <= sum_q[cmd_i.ch] + v_ext;
        sumsq_q[cmd_i.ch] <= sumsq_q[cmd_i.ch] + vsq_ext;
        if (v > mx_q[cmd_i.ch]) begin
          mx_q[cmd_i.ch] <= v;
        end
        if (v < mn_q[cmd_i.ch]) begin
          mn_q[cmd_i.ch] <= v;
        end
      end
    end
  end

  assign neg           = sum_r_q[RW-1];
  assign mag           = neg ? RW'(-sum_r_q) : RW'(sum_r_q);
  assign mean_dividend = {mag, 1'b0} + W_DW;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sum_r_q   <= sum_q[cmd_i.ch];
      sumsq_r_q <= sumsq_q[cmd_i.ch];
      mx_r_q    <= mx_q[cmd_i.ch];
      mn_r_q    <= mn_q[cmd_i.ch];
    end
    if (cmd_i.sq) begin
      magsq_q <= SPW'(mag) * SPW'(mag);
    end
    if (cmd_i.spread) begin
      spread_q <= SPW'(sumsq_r_q) * W_SP - magsq_q;
    end
  end

  swcs_sqrt #(
    .ROOT_W(RW)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.root_start),
    .radicand_i(spread_q),
    .busy_o    (root_busy),
    .root_o    (root)
  );

  swcs_div #(
    .DIVIDEND_W(DW),
    .DIVISOR   (2 * WINDOW_LEN)
  ) u_mean_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mean_start),
    .dividend_i(mean_dividend),
    .busy_o    (mean_busy),
    .quotient_o(mean_quo)
  );

  swcs_div #(
    .DIVIDEND_W(DW),
    .DIVISOR   (WINDOW_LEN)
  ) u_sd_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.sd_start),
    .dividend_i({1'b0, root}),
    .busy_o    (sd_busy),
    .quotient_o(sd_quo)
  );

  assign mean_mag = mean_quo[S-1:0];

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      channel_o        <= cmd_i.ch;
      mean_value_o     <= neg ? (~mean_mag + 1'b1) : mean_mag;
      std_value_o      <= sd_quo[S-1:0];
      max_value_o      <= mx_r_q;
      min_value_o      <= mn_r_q;
      span_value_o     <= mx_r_q - mn_r_q;
      last_of_window_o <= (cmd_i.ch == swcs_pkg::CH_LAST);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.root_busy = root_busy;
  assign sts_o.mean_busy = mean_busy;
  assign sts_o.sd_busy   = sd_busy;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

FILE: rtl/swcs_ctrl.sv
`default_nettype none

module swcs_ctrl #(
  parameter int unsigned WINDOW_LEN = swcs_pkg::WINDOW_LEN_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           start_window_i,
  input  wire swcs_pkg::sts_t sts_i,
  output swcs_pkg::cmd_t      cmd_o
);

  localparam int unsigned FW = $clog2(WINDOW_LEN + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_LEN);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ACC    = 4'd1;
  localparam logic [3:0] ST_LATCH  = 4'd2;
  localparam logic [3:0] ST_SQ     = 4'd3;
  localparam logic [3:0] ST_SPREAD = 4'd4;
  localparam logic [3:0] ST_RSTART = 4'd5;
  localparam logic [3:0] ST_RWAIT  = 4'd6;
  localparam logic [3:0] ST_DSTART = 4'd7;
  localparam logic [3:0] ST_DWAIT  = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  logic [3:0]                state_q, state_d;
  logic [swcs_pkg::CH_W-1:0] ch_q, ch_d;
  logic [FW-1:0]             fill_q, fill_d;
  logic                      init_q, init_d;
  logic                      end_q, end_d;
  logic [FW-1:0]             base;
  logic [FW-1:0]             nxt;
  logic                      accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign base   = start_window_i ? '0 : fill_q;
  assign nxt    = base + 1'b1;

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    fill_d  = fill_q;
    init_d  = init_q;
    end_d   = end_q;
    cmd_o   = '0;
    cmd_o.ch = ch_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.cap = 1'b1;
          init_d    = (base == '0);
          end_d     = (nxt == FILL_FULL);
          fill_d    = (nxt == FILL_FULL) ? FW'(1) : nxt;
          ch_d      = '0;
          state_d   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc_we   = 1'b1;
        cmd_o.acc_init = init_q;
        if (ch_q == swcs_pkg::CH_LAST) begin
          ch_d    = '0;
          state_d = end_q ? ST_LATCH : ST_IDLE;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      ST_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d     = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq         = 1'b1;
        cmd_o.mean_start = 1'b1;
        state_d          = ST_SPREAD;
      end
      ST_SPREAD: begin
        cmd_o.spread = 1'b1;
        state_d      = ST_RSTART;
      end
      ST_RSTART: begin
        cmd_o.root_start = 1'b1;
        state_d          = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (!sts_i.root_busy) begin
          state_d = ST_DSTART;
        end
      end
      ST_DSTART: begin
        cmd_o.sd_start = 1'b1;
        state_d        = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!sts_i.sd_busy && !sts_i.mean_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (ch_q == swcs_pkg::CH_LAST) begin
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_LATCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      fill_q  <= '0;
      init_q  <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      fill_q  <= fill_d;
      init_q  <= init_d;
      end_q   <= end_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire
